// ===== rtl/preemptive_priority_scheduler_assert.svh =====
// Assertion macros used by the scheduler back end.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define PPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define PPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants, codes and types of the priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int ID_W        = 16;
   localparam int PRI_W       = 8;
   localparam int RUN_W       = 16;
   localparam int TIME_W      = 32;
   localparam int ORD_W       = 32;
   localparam int FIFO_DEPTH  = 2;
   localparam int FPTR_W      = $clog2(FIFO_DEPTH);
   localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic OP_ARRIVAL  = 1'b0;
   localparam logic OP_DRAIN    = 1'b1;
   localparam logic KIND_DONE   = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   typedef struct packed {
      logic              is_drain;
      logic [ID_W-1:0]   id;
      logic [PRI_W-1:0]  pri;
      logic [RUN_W-1:0]  run;
      logic [TIME_W-1:0] arr;
   } cmd_type;

   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] fin;
   } result_type;

endpackage

// ===== rtl/pps_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_if
// Request and response channel interfaces of the priority scheduler.
// ----------------------------------------------------------------------------
interface pps_req_if import pps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [ID_W-1:0]   task_id;
   logic [PRI_W-1:0]  task_priority;
   logic [RUN_W-1:0]  run_time;
   logic [TIME_W-1:0] arrival_time;

   modport source (output valid, opcode, task_id, task_priority, run_time, arrival_time,
                   input ready);
   modport sink   (input valid, opcode, task_id, task_priority, run_time, arrival_time,
                   output ready);
endinterface

interface pps_rsp_if import pps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ID_W-1:0]   done_id;
   logic [TIME_W-1:0] finish_time;
   logic              last;

   modport source (output valid, kind, done_id, finish_time, last, input ready);
   modport sink   (input valid, kind, done_id, finish_time, last, output ready);
endinterface

// ===== rtl/pps_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_front
// Accept request transfers, classify them and hold them in a short queue.
// ----------------------------------------------------------------------------
module pps_front import pps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   pps_req_if.sink req,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type           q_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;
   cmd_type           new_cmd;

   assign req.ready = count_ff != FCNT_W'(FIFO_DEPTH);
   assign push      = req.valid && req.ready;
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_valid = count_ff != '0;
   assign cmd       = q_ff[rd_ptr_ff];

   // classify: drain items carry no task
   always_comb begin
      new_cmd.is_drain = req.opcode == OP_DRAIN;
      new_cmd.id       = req.task_id;
      new_cmd.pri      = req.task_priority;
      new_cmd.run      = req.run_time;
      new_cmd.arr      = req.arrival_time;
   end

   always_comb begin
      wr_ptr_in = push ? FPTR_W'((32'(wr_ptr_ff) + 1) % FIFO_DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop  ? FPTR_W'((32'(rd_ptr_ff) + 1) % FIFO_DEPTH) : rd_ptr_ff;
      count_in  = count_ff + FCNT_W'(push) - FCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== rtl/pps_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_back
// Run queued tasks: scan for the best slot, retire, preempt, insert or reject.
// ----------------------------------------------------------------------------
`include "preemptive_priority_scheduler_assert.svh"

module pps_back import pps_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   pps_rsp_if.source rsp
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_FLUSH  = 2'd3;

   logic [1:0]             state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [SLOT_W-1:0]      scan_ff, scan_in;
   logic                   have_best_ff, have_best_in;
   logic [SLOT_W-1:0]      best_idx_ff, best_idx_in;
   logic [PRI_W-1:0]       best_pri_ff, best_pri_in;
   logic [TIME_W-1:0]      best_arr_ff, best_arr_in;
   logic [ORD_W-1:0]       best_ord_ff, best_ord_in;
   logic [RUN_W-1:0]       best_rem_ff, best_rem_in;
   logic [ID_W-1:0]        best_id_ff, best_id_in;
   logic                   have_free_ff, have_free_in;
   logic [SLOT_W-1:0]      free_idx_ff, free_idx_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [ORD_W-1:0]       ins_ff, ins_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic                   pend_valid_ff, pend_valid_in;
   result_type             pend_ff, pend_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;
   logic                   out_last_ff, out_last_in;

   logic [ID_W-1:0]   slot_id   [QUEUE_DEPTH];
   logic [PRI_W-1:0]  slot_pri  [QUEUE_DEPTH];
   logic [RUN_W-1:0]  slot_rem  [QUEUE_DEPTH];
   logic [TIME_W-1:0] slot_arr  [QUEUE_DEPTH];
   logic [ORD_W-1:0]  slot_ord  [QUEUE_DEPTH];

   logic              cur_better;
   logic              scan_last;
   logic              out_free;
   logic [TIME_W:0]   fin_sum;
   logic [TIME_W-1:0] fin_val;
   logic [TIME_W-1:0] arr_eff;
   logic [TIME_W-1:0] gap;
   logic              run_cond;
   logic              complete;
   logic              emit_new;
   logic              stall;
   logic              insert_fire;
   logic              preempt_fire;

   assign scan_last = scan_ff == SLOT_W'(QUEUE_DEPTH - 1);
   assign out_free  = !out_valid_ff || rsp.ready;

   // ordering: priority, then arrival, then insertion stamp
   assign cur_better = !have_best_ff
      || (slot_pri[scan_ff] > best_pri_ff)
      || (slot_pri[scan_ff] == best_pri_ff && slot_arr[scan_ff] < best_arr_ff)
      || (slot_pri[scan_ff] == best_pri_ff && slot_arr[scan_ff] == best_arr_ff
          && slot_ord[scan_ff] < best_ord_ff);

   assign fin_sum  = {1'b0, now_ff} + {{(TIME_W + 1 - RUN_W){1'b0}}, best_rem_ff};
   assign fin_val  = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
   assign arr_eff  = (now_ff < cmd_ff.arr) ? cmd_ff.arr : now_ff;
   assign gap      = cmd_ff.arr - now_ff;
   assign run_cond = have_best_ff && (cmd_ff.is_drain || now_ff < cmd_ff.arr);
   assign complete = run_cond
      && (cmd_ff.is_drain || fin_sum <= {1'b0, cmd_ff.arr});
   assign emit_new = complete || (!run_cond && !cmd_ff.is_drain && !have_free_ff);
   assign stall    = emit_new && pend_valid_ff && !out_free;

   assign insert_fire  = state_ff == ST_DECIDE && !run_cond && !cmd_ff.is_drain
                         && have_free_ff;
   assign preempt_fire = state_ff == ST_DECIDE && run_cond && !complete;
   assign cmd_pop      = state_ff == ST_IDLE;

   assign rsp.valid       = out_valid_ff;
   assign rsp.kind        = out_ff.kind;
   assign rsp.done_id     = out_ff.id;
   assign rsp.finish_time = out_ff.fin;
   assign rsp.last        = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      scan_in       = scan_ff;
      have_best_in  = have_best_ff;
      best_idx_in   = best_idx_ff;
      best_pri_in   = best_pri_ff;
      best_arr_in   = best_arr_ff;
      best_ord_in   = best_ord_ff;
      best_rem_in   = best_rem_ff;
      best_id_in    = best_id_ff;
      have_free_in  = have_free_ff;
      free_idx_in   = free_idx_ff;
      now_in        = now_ff;
      ins_in        = ins_ff;
      valid_in      = valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in       = cmd;
               scan_in      = '0;
               have_best_in = 1'b0;
               have_free_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (valid_ff[scan_ff]) begin
               if (cur_better) begin
                  have_best_in = 1'b1;
                  best_idx_in  = scan_ff;
                  best_pri_in  = slot_pri[scan_ff];
                  best_arr_in  = slot_arr[scan_ff];
                  best_ord_in  = slot_ord[scan_ff];
                  best_rem_in  = slot_rem[scan_ff];
                  best_id_in   = slot_id[scan_ff];
               end
            end else if (!have_free_ff) begin
               have_free_in = 1'b1;
               free_idx_in  = scan_ff;
            end
            if (scan_last) begin
               state_in = ST_DECIDE;
            end else begin
               scan_in = scan_ff + SLOT_W'(1);
            end
         end
         ST_DECIDE: begin
            if (!stall) begin
               if (emit_new) begin
                  // push older result out, keep newest back to learn its last flag
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_in       = pend_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  if (complete) begin
                     pend_in = '{kind: KIND_DONE, id: best_id_ff, fin: fin_val};
                  end else begin
                     pend_in = '{kind: KIND_REJECT, id: cmd_ff.id, fin: '0};
                  end
               end
               if (complete) begin
                  now_in                = fin_val;
                  valid_in[best_idx_ff] = 1'b0;
                  scan_in               = '0;
                  have_best_in          = 1'b0;
                  have_free_in          = 1'b0;
                  state_in              = ST_SCAN;
               end else if (run_cond) begin
                  // preempt: clock reaches arrival, stay to insert
                  now_in      = cmd_ff.arr;
                  best_rem_in = best_rem_ff - gap[RUN_W-1:0];
               end else begin
                  if (!cmd_ff.is_drain) begin
                     now_in = arr_eff;
                     if (have_free_ff) begin
                        valid_in[free_idx_ff] = 1'b1;
                        ins_in                = ins_ff + ORD_W'(1);
                     end
                  end
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         ins_ff        <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         have_best_ff  <= 1'b0;
         have_free_ff  <= 1'b0;
         scan_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         ins_ff        <= ins_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         have_best_ff  <= have_best_in;
         have_free_ff  <= have_free_in;
         scan_ff       <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      best_idx_ff <= best_idx_in;
      best_pri_ff <= best_pri_in;
      best_arr_ff <= best_arr_in;
      best_ord_ff <= best_ord_in;
      best_rem_ff <= best_rem_in;
      best_id_ff  <= best_id_in;
      free_idx_ff <= free_idx_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   // slot store: one write per cycle, insert or preempt
   always_ff @(posedge clock) begin
      if (insert_fire) begin
         slot_id[free_idx_ff]  <= cmd_ff.id;
         slot_pri[free_idx_ff] <= cmd_ff.pri;
         slot_rem[free_idx_ff] <= cmd_ff.run;
         slot_arr[free_idx_ff] <= arr_eff;
         slot_ord[free_idx_ff] <= ins_ff;
      end else if (preempt_fire) begin
         slot_rem[best_idx_ff] <= best_rem_ff - gap[RUN_W-1:0];
      end
   end

   `PPS_ASSERT_NOW(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_valid_ff,
      "pending result left behind at idle")
   `PPS_ASSERT_NEXT(a_insert_stamp, clock, reset, insert_fire,
      ins_ff == $past(ins_ff) + ORD_W'(1), "insert stamp did not advance")
   `PPS_ASSERT_NOW(a_clock_mono, clock, reset, !$past(reset),
      now_ff >= $past(now_ff), "processor clock went backwards")
   `PPS_ASSERT_NEXT(a_complete_frees, clock, reset, state_ff == ST_DECIDE && complete && !stall,
      !valid_ff[$past(best_idx_ff)], "completed slot still valid")

endmodule

// ===== rtl/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Single processor preemptive priority scheduler with a sixteen slot queue.
// ----------------------------------------------------------------------------
// Each request transfer is either a task arrival or a drain. Before an arrival
// is queued the block runs waiting tasks (highest priority, then earliest
// arrival, then earliest insertion) up to the arrival time, reporting each
// finished task, and an arrival rejected for a full queue, on the response
// channel; the last response of a request has last set, and a request that
// causes no result gives no response. The back end takes a command, scans
// the slot store one slot per clock for each decision, retires, preempts,
// inserts or rejects, and flushes the last result; a waiting response can
// hold it back. A two-entry command queue lets requests be taken while the
// back end is busy, and the response register lets the next result be built
// while the previous transfer waits.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pps_req_if.sink   req_ch,
   pps_rsp_if.source rsp_ch
);

   // command hand-off between front and back
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // front: accept and classify, hold in the command queue
   pps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // back: scan slots, retire, preempt, insert or reject, drive responses
   pps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_ch)
   );

endmodule
